// ----- rtl/core/csa_pkg.sv -----
// Package for the chi-square accumulator: payload structs, queue entry,
// back-end state type and fixed arithmetic constants. No dependencies.
package csa_pkg;

  // Fixed-point format and count limits
  localparam int FRAC_BITS       = 16;
  localparam int MAX_BINS        = 65536;
  localparam int COUNT_W         = 17;
  localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
  localparam int COUNT_CAP_INT   = (MAX_BINS < COUNT_FIELD_MAX) ? MAX_BINS : COUNT_FIELD_MAX;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);

  // Divider geometry: |fit - data| is 33 bits, shifted up by FRAC_BITS
  localparam int MAG_W   = 33;
  localparam int DVD_W   = MAG_W + FRAC_BITS;
  localparam int STEP_W  = $clog2(DVD_W);
  localparam int RATIO_W = 31;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam int TERM_W  = 2 * RATIO_W;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration register map
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_WIN_EN   = 2'd0;
  localparam logic [1:0] REG_WIN_LOW  = 2'd1;
  localparam logic [1:0] REG_WIN_HIGH = 2'd2;

  typedef struct packed {
    logic signed [31:0] fit_content;
    logic signed [31:0] data_content;
    logic [31:0]        data_error;
    logic signed [31:0] center_pos;
    logic               last_bin;
  } bin_t;

  typedef struct packed {
    logic [63:0]        chi_square_sum;
    logic [COUNT_W-1:0] nonempty_count;
  } result_t;

  // One classified bin waiting for the back end
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [31:0]      err;
    logic             count_inc;
    logic             use_term;
    logic             last;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ACC
  } back_state_t;

endpackage

// ----- rtl/core/csa_front.sv -----
// Front end: applies the centre window and classifies each bin into a job.
// Depends on csa_pkg.
module csa_front (
  input  csa_pkg::bin_t       bin,
  input  logic                window_enable,
  input  logic signed [31:0]  window_low,
  input  logic signed [31:0]  window_high,
  output csa_pkg::job_t       job
);
  import csa_pkg::*;

  logic               in_window;
  logic signed [32:0] delta;

  // Window test on the bin centre
  assign in_window = !window_enable ||
                     ((bin.center_pos >= window_low) && (bin.center_pos <= window_high));

  // Exact difference and its magnitude
  assign delta = 33'(bin.fit_content) - 33'(bin.data_content);

  always_comb begin
    job.mag       = delta[32] ? MAG_W'(-delta) : MAG_W'(delta);
    job.err       = bin.data_error;
    job.count_inc = in_window && (bin.data_content != '0);
    job.use_term  = in_window && (bin.data_error != '0);
    job.last      = bin.last_bin;
  end

endmodule

// ----- rtl/core/csa_fifo.sv -----
// Short job queue that decouples the front end from the back end.
// Depends on csa_pkg.
module csa_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  csa_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output csa_pkg::job_t pop_data
);
  import csa_pkg::*;

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;

  assign full     = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue fill above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> fill == (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue lost an entry");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    empty && !push |=> empty) else $error("queue grew without a push");

endmodule

// ----- rtl/core/csa_back.sv -----
// Back end: bit-serial divide, square, saturating accumulate and result register.
// Depends on csa_pkg.
module csa_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  csa_pkg::job_t    job,
  output logic             job_pop,
  output logic             result_valid,
  input  logic             result_ready,
  output csa_pkg::result_t result
);
  import csa_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  job_t                 cur;
  logic [DVD_W-1:0]     dvd;
  logic [31:0]          rem;
  logic [DVD_W-1:0]     quo;
  logic [STEP_W-1:0]    step;
  logic [TERM_W-1:0]    term;
  logic [63:0]          sum;
  logic [COUNT_W-1:0]   count;

  logic [32:0]          trial;
  logic                 ge;
  logic [RATIO_W-1:0]   q_sat;
  logic [64:0]          sum_add;
  logic [63:0]          sum_new;
  logic [COUNT_W-1:0]   count_new;
  logic                 out_free;
  logic                 acc_go;

  // One restoring divide step
  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = (trial >= {1'b0, cur.err});

  // Saturate the ratio to unsigned Q15.16
  assign q_sat = (quo > DVD_W'(RATIO_MAX)) ? RATIO_MAX : quo[RATIO_W-1:0];

  // Saturating add and capped count
  assign sum_add   = {1'b0, sum} + 65'(term);
  assign sum_new   = sum_add[64] ? '1 : sum_add[63:0];
  assign count_new = (cur.count_inc && (count < COUNT_CAP)) ? count + 1'b1 : count;

  assign out_free = !result_valid || result_ready;
  assign acc_go   = !cur.last || out_free;
  assign job_pop  = (state == ST_IDLE) && job_valid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          state_next = job.use_term ? ST_DIV : ST_ACC;
        end
      end
      ST_DIV: begin
        if (step == STEP_W'(DVD_W - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: begin
        if (acc_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur  <= job;
        dvd  <= {job.mag, FRAC_BITS'(0)};
        rem  <= '0;
        quo  <= '0;
        step <= '0;
        term <= '0;
      end
      ST_DIV: begin
        rem  <= ge ? 32'(trial - {1'b0, cur.err}) : trial[31:0];
        quo  <= {quo[DVD_W-2:0], ge};
        dvd  <= {dvd[DVD_W-2:0], 1'b0};
        step <= step + 1'b1;
      end
      ST_MUL: begin
        term <= q_sat * q_sat;
      end
      default: begin
      end
    endcase
  end

  // Accumulator, counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_ACC && acc_go && cur.last) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (state == ST_ACC && acc_go) begin
        if (cur.last) begin
          result.chi_square_sum <= sum_new;
          result.nonempty_count <= count_new;
          sum                   <= '0;
          count                 <= '0;
        end else begin
          sum   <= sum_new;
          count <= count_new;
        end
      end
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_CAP) else $error("bin count above cap");
  a_term_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> term <= TERM_W'(RATIO_MAX) * TERM_W'(RATIO_MAX))
    else $error("term above saturated square");
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> step < STEP_W'(DVD_W)) else $error("divider overran");
  a_result_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC && acc_go && cur.last |=> sum == '0 && count == '0)
    else $error("state not cleared after last bin");

endmodule

// ----- rtl/core/chi_square_accumulator_unit.sv -----
// Top level of the chi-square accumulator: configuration registers, front end,
// job queue and back end. Depends on csa_pkg, csa_front, csa_fifo, csa_back.
//
// Bins enter on the bin channel (valid/ready); one result leaves on the
// result channel for each bin marked last_bin, holding the saturated Q32.32
// sum of ((fit - data) / error)^2 and the count of nonempty in-window bins.
// The window registers are written over the APB port at addresses 0, 4, 8.
// A bin is classified on entry and placed in a four-entry queue; with one bin
// in the back end, up to five bins are taken before the arithmetic catches up.
// The back end divides one quotient bit per cycle: a bin that adds a term
// is popped, divided over a 49-bit quotient, squared and accumulated; a
// skipped bin is popped and accumulated. Division sets sustained throughput.
// result_valid is set when the last bin is accumulated, once the output is free.
// Reset clears the sum, the count and the queue, disables the window and
// opens its bounds to the full range.
// When the receiver stalls, the result is held; a further last bin waits in
// the back end, and the queue then fills and drops bin_ready.
module chi_square_accumulator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         bin_valid,
  output logic                         bin_ready,
  input  csa_pkg::bin_t                bin,
  output logic                         result_valid,
  input  logic                         result_ready,
  output csa_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csa_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import csa_pkg::*;

  logic               window_enable;
  logic signed [31:0] window_low;
  logic signed [31:0] window_high;
  logic [1:0]         reg_idx;
  job_t               front_job;
  job_t               queue_job;
  logic               queue_full;
  logic               queue_empty;
  logic               job_pop;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign bin_ready = !queue_full;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_enable <= 1'b0;
      window_low    <= 32'sh8000_0000;
      window_high   <= 32'sh7FFF_FFFF;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WIN_EN:   window_enable <= pwdata[0];
        REG_WIN_LOW:  window_low    <= pwdata;
        REG_WIN_HIGH: window_high   <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    case (reg_idx)
      REG_WIN_EN:   prdata = {31'd0, window_enable};
      REG_WIN_LOW:  prdata = window_low;
      REG_WIN_HIGH: prdata = window_high;
      default:      prdata = '0;
    endcase
  end

  csa_front u_front (
    .bin           (bin),
    .window_enable (window_enable),
    .window_low    (window_low),
    .window_high   (window_high),
    .job           (front_job)
  );

  csa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (bin_valid),
    .push_data (front_job),
    .full      (queue_full),
    .pop       (job_pop),
    .empty     (queue_empty),
    .pop_data  (queue_job)
  );

  csa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (!queue_empty),
    .job          (queue_job),
    .job_pop      (job_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
